// ===== rtl/bsal_pkg.sv =====
// package for the any-length bitonic sorter
// beat structs, element record, command, register and state codes; no dependencies
`default_nettype none

package bsal_pkg;

    localparam int KEY_BITS         = 32;
    localparam int PAYLOAD_BITS     = 32;
    localparam int INDEX_BITS       = 10;
    localparam int CFG_BITS         = 11;
    localparam int DEFAULT_DEPTH    = 1024;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_SORT  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_SORT_ASC    = 2'd0,
        CFG_BY_DUMMY    = 2'd1,
        CFG_RANGE_FIRST = 2'd2,
        CFG_RANGE_END   = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_POP,
        S_CX_RD,
        S_CX_CMP,
        S_CX_WJ
    } state_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]     key;
        logic                    dummy;
        logic [PAYLOAD_BITS-1:0] payload;
    } elem_t;

    typedef struct packed {
        logic [1:0]              cmd;
        logic [INDEX_BITS-1:0]   index;
        logic [KEY_BITS-1:0]     key_in;
        logic                    dummy_in;
        logic [PAYLOAD_BITS-1:0] payload_in;
    } in_beat_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]     key_out;
        logic                    dummy_out;
        logic [PAYLOAD_BITS-1:0] payload_out;
        logic                    sort_done;
    } out_beat_t;

endpackage

`default_nettype wire

// ===== rtl/bsal_store.sv =====
// element store: one write port, two registered read ports
// depends on bsal_pkg for the element record
`default_nettype none

module bsal_store
    import bsal_pkg::*;
#(
    parameter int STORE_DEPTH = DEFAULT_DEPTH,
    parameter int AW          = $clog2(STORE_DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire elem_t         wr_data,
    input  wire logic [AW-1:0] rd_addr_a,
    input  wire logic [AW-1:0] rd_addr_b,
    output elem_t              rd_data_a,
    output elem_t              rd_data_b
);

    elem_t mem [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

// ===== rtl/bitonic_sort_any_length.sv =====
// top level of the any-length bitonic sorter: command fsm, task stack, output register
// depends on bsal_pkg and bsal_store
//
//   channel   direction  handshake          content
//   in        input      in_valid/in_ready  in_beat_t: write, sort, read or no-op
//   out       output     out_valid/out_ready out_beat_t: read element or sort done
//   cfg       input      cfg_we             cfg_index, cfg_data
//
// a write goes to the store when accepted; a read passes through S_READ before out_valid rises
// a sort runs from a task stack: S_POP per popped task, S_CX_RD and S_CX_CMP per
// compare-exchange that keeps its pair, plus S_CX_WJ per swap (store write port)
// rst_n clears fsm, stack pointer, output valid and registers to their reset values
// read and sort beats are taken only once the output register is free or emptying
`default_nettype none

module bitonic_sort_any_length
    import bsal_pkg::*;
#(
    parameter int STORE_DEPTH = DEFAULT_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire in_beat_t            in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output out_beat_t                out_data,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [CFG_BITS-1:0] cfg_data
);

    localparam int AW        = $clog2(STORE_DEPTH);
    localparam int RW        = AW + 1;
    // deepest nesting is two frames per halving plus the leaf
    localparam int STK_DEPTH = 2 * AW + 4;
    localparam int SIW       = $clog2(STK_DEPTH);
    localparam int SPW       = $clog2(STK_DEPTH + 1);

    typedef struct packed {
        logic          is_merge;
        logic          up;
        logic [RW-1:0] lo;
        logic [RW-1:0] hi;
    } frame_t;

    // configuration
    logic                sort_asc_reg;
    logic                by_dummy_reg;
    logic [CFG_BITS-1:0] range_first_reg;
    logic [CFG_BITS-1:0] range_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sort_asc_reg    <= 1'b1;
            by_dummy_reg    <= 1'b0;
            range_first_reg <= '0;
            range_end_reg   <= CFG_BITS'(1024);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SORT_ASC:    sort_asc_reg    <= cfg_data[0];
                CFG_BY_DUMMY:    by_dummy_reg    <= cfg_data[0];
                CFG_RANGE_FIRST: range_first_reg <= cfg_data;
                CFG_RANGE_END:   range_end_reg   <= cfg_data;
                default:         sort_asc_reg    <= sort_asc_reg;
            endcase
        end
    end

    // store
    logic          st_we;
    logic [AW-1:0] st_waddr;
    elem_t         st_wdata;
    logic [AW-1:0] st_raddr_a;
    logic [AW-1:0] st_raddr_b;
    elem_t         st_rdata_a;
    elem_t         st_rdata_b;

    bsal_store #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_store (
        .clk       (clk),
        .wr_en     (st_we),
        .wr_addr   (st_waddr),
        .wr_data   (st_wdata),
        .rd_addr_a (st_raddr_a),
        .rd_addr_b (st_raddr_b),
        .rd_data_a (st_rdata_a),
        .rd_data_b (st_rdata_b)
    );

    // control registers
    state_t         state_reg,     state_next;
    logic [SPW-1:0] sp_reg,        sp_next;
    logic [RW-1:0]  cx_i_reg,      cx_i_next;
    logic [RW-1:0]  cx_m_reg,      cx_m_next;
    logic [RW-1:0]  cx_end_reg,    cx_end_next;
    logic           cx_up_reg,     cx_up_next;
    elem_t          cx_a_reg,      cx_a_next;
    logic           rd_ok_reg,     rd_ok_next;
    logic           out_valid_reg, out_valid_next;
    out_beat_t      out_data_reg,  out_data_next;

    frame_t stk [STK_DEPTH];
    logic   [2:0]   stk_we;
    logic   [SIW-1:0] stk_idx [3];
    frame_t stk_wdata [3];

    logic          in_acc;
    logic          out_free;
    logic          idx_ok;
    logic [RW-1:0] sort_lo;
    logic [RW-1:0] sort_hi;
    frame_t        top;
    logic [SPW-1:0] base;
    logic [RW-1:0] len;
    logic [RW-1:0] len_m1;
    logic [RW-1:0] mid;
    logic [RW-1:0] pw;
    logic [RW-1:0] cx_j;
    logic [RW-1:0] cx_i_inc;
    logic          less;
    logic          swap;

    assign out_free = !out_valid_reg || out_ready;
    assign idx_ok   = 32'(in_data.index) < 32'(STORE_DEPTH);
    assign sort_lo  = (32'(range_first_reg) > 32'(STORE_DEPTH)) ? RW'(STORE_DEPTH)
                                                               : RW'(range_first_reg);
    assign sort_hi  = (32'(range_end_reg) > 32'(STORE_DEPTH)) ? RW'(STORE_DEPTH)
                                                             : RW'(range_end_reg);

    assign in_ready = (state_reg == S_IDLE) &&
                      (in_data.cmd == CMD_WRITE || in_data.cmd == CMD_NOP || out_free);
    assign in_acc   = in_valid && in_ready;

    assign base   = sp_reg - SPW'(1);
    assign top    = stk[base[SIW-1:0]];
    assign len    = top.hi - top.lo;
    assign len_m1 = len - RW'(1);
    assign mid    = top.lo + (len >> 1);
    assign cx_j     = cx_i_reg + cx_m_reg;
    assign cx_i_inc = cx_i_reg + RW'(1);

    // largest power of two below len: top set bit of len-1
    always_comb
    begin
        pw = '0;
        for (int b = 0; b < RW; b++)
        begin
            if (len_m1[b])
            begin
                pw = RW'(1) << b;
            end
        end
    end

    assign less = by_dummy_reg ? (st_rdata_a.dummy < st_rdata_b.dummy)
                               : (st_rdata_a.key < st_rdata_b.key);
    assign swap = less != cx_up_reg;

    always_comb
    begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        cx_i_next      = cx_i_reg;
        cx_m_next      = cx_m_reg;
        cx_end_next    = cx_end_reg;
        cx_up_next     = cx_up_reg;
        cx_a_next      = cx_a_reg;
        rd_ok_next     = rd_ok_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        st_we      = 1'b0;
        st_waddr   = AW'(in_data.index);
        st_wdata   = '{key: in_data.key_in, dummy: in_data.dummy_in,
                       payload: in_data.payload_in};
        st_raddr_a = AW'(in_data.index);
        st_raddr_b = AW'(cx_j);
        stk_we     = '0;
        for (int k = 0; k < 3; k++)
        begin
            stk_idx[k]   = SIW'(base + SPW'(k));
            stk_wdata[k] = top;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (cmd_t'(in_data.cmd))
                        CMD_WRITE:
                        begin
                            st_we = idx_ok;
                        end
                        CMD_READ:
                        begin
                            rd_ok_next = idx_ok;
                            state_next = S_READ;
                        end
                        CMD_SORT:
                        begin
                            stk_we[0]    = 1'b1;
                            stk_idx[0]   = '0;
                            stk_wdata[0] = '{is_merge: 1'b0, up: sort_asc_reg,
                                             lo: sort_lo, hi: sort_hi};
                            sp_next      = SPW'(1);
                            state_next   = S_POP;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                out_valid_next = 1'b1;
                out_data_next  = '{key_out: rd_ok_reg ? st_rdata_a.key : '0,
                                   dummy_out: rd_ok_reg && st_rdata_a.dummy,
                                   payload_out: rd_ok_reg ? st_rdata_a.payload : '0,
                                   sort_done: 1'b0};
                state_next     = S_IDLE;
            end
            S_POP:
            begin
                if (sp_reg == '0)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{key_out: '0, dummy_out: 1'b0,
                                       payload_out: '0, sort_done: 1'b1};
                    state_next     = S_IDLE;
                end
                else if (top.hi > top.lo && len >= RW'(2))
                begin
                    if (!top.is_merge)
                    begin
                        // merge runs after both halves, so it goes deepest
                        stk_we       = 3'b111;
                        stk_wdata[0] = '{is_merge: 1'b1, up: top.up,
                                         lo: top.lo, hi: top.hi};
                        stk_wdata[1] = '{is_merge: 1'b0, up: top.up,
                                         lo: mid, hi: top.hi};
                        stk_wdata[2] = '{is_merge: 1'b0, up: !top.up,
                                         lo: top.lo, hi: mid};
                        sp_next      = sp_reg + SPW'(2);
                    end
                    else
                    begin
                        stk_we       = 3'b011;
                        stk_wdata[0] = '{is_merge: 1'b1, up: top.up,
                                         lo: top.lo + pw, hi: top.hi};
                        stk_wdata[1] = '{is_merge: 1'b1, up: top.up,
                                         lo: top.lo, hi: top.lo + pw};
                        sp_next      = sp_reg + SPW'(1);
                        cx_i_next    = top.lo;
                        cx_m_next    = pw;
                        cx_end_next  = top.hi - pw;
                        cx_up_next   = top.up;
                        state_next   = S_CX_RD;
                    end
                end
                else
                begin
                    sp_next = base;
                end
            end
            S_CX_RD:
            begin
                st_raddr_a = AW'(cx_i_reg);
                state_next = S_CX_CMP;
            end
            S_CX_CMP:
            begin
                cx_a_next = st_rdata_a;
                if (swap)
                begin
                    st_we      = 1'b1;
                    st_waddr   = AW'(cx_i_reg);
                    st_wdata   = st_rdata_b;
                    state_next = S_CX_WJ;
                end
                else
                begin
                    cx_i_next  = cx_i_inc;
                    state_next = (cx_i_inc < cx_end_reg) ? S_CX_RD : S_POP;
                end
            end
            S_CX_WJ:
            begin
                st_we      = 1'b1;
                st_waddr   = AW'(cx_j);
                st_wdata   = cx_a_reg;
                cx_i_next  = cx_i_inc;
                state_next = (cx_i_inc < cx_end_reg) ? S_CX_RD : S_POP;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_i_reg     <= cx_i_next;
        cx_m_reg     <= cx_m_next;
        cx_end_reg   <= cx_end_next;
        cx_up_reg    <= cx_up_next;
        cx_a_reg     <= cx_a_next;
        rd_ok_reg    <= rd_ok_next;
        out_data_reg <= out_data_next;
        for (int k = 0; k < 3; k++)
        begin
            if (stk_we[k])
            begin
                stk[stk_idx[k]] <= stk_wdata[k];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(sp_reg) <= STK_DEPTH)
        else $error("task stack overflow");

    a_pair_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CX_RD) |-> (32'(cx_i_reg) + 32'(cx_m_reg) < 32'(STORE_DEPTH)))
        else $error("compare pair outside store");

    a_sort_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.cmd == CMD_SORT) |=>
            (state_reg == S_POP && sp_reg == SPW'(1)))
        else $error("sort did not start");

endmodule

`default_nettype wire

// ===== verif/bitonic_sort_any_length_test.sv =====
// testbench for the any-length bitonic sorter: directed and random writes, sorts and reads
// checked against an element-store predictor; depends on bsal_pkg and the sorter rtl
`default_nettype none

module bitonic_sort_any_length_test;
    import bsal_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = DEFAULT_DEPTH;
    localparam longint LIMIT = 60000000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    in_beat_t            in_data;
    logic                out_valid;
    logic                out_ready;
    out_beat_t           out_data;
    logic                cfg_we;
    logic [1:0]          cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    bitonic_sort_any_length uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    elem_t     shadow_store [DEPTH];
    bit        written [DEPTH];
    bit        pred_asc;
    bit        pred_by_dummy;
    int        pred_first;
    int        pred_end;
    out_beat_t expected_beats [$];
    int        error_count;
    longint    cycle_count;
    bit        hold_off;
    int        hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report(input string what);
        error_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off)
        begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles >= 3000)
                hold_off <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 9) < 7)
                out_ready <= 1'b1;
            else if ($urandom_range(0, 19) == 0)
                out_ready <= 1'b0;
            else
                out_ready <= ($urandom_range(0, 2) == 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_beats.size() == 0)
                report("result beat with nothing expected");
            else
            begin
                out_beat_t want;
                want = expected_beats.pop_front();
                if (out_data.sort_done !== want.sort_done)
                    report($sformatf("sort_done %b want %b", out_data.sort_done, want.sort_done));
                if (out_data.key_out !== want.key_out)
                    report($sformatf("key %h want %h", out_data.key_out, want.key_out));
                if (out_data.dummy_out !== want.dummy_out)
                    report($sformatf("dummy %b want %b", out_data.dummy_out, want.dummy_out));
                if (out_data.payload_out !== want.payload_out)
                    report($sformatf("payload %h want %h", out_data.payload_out,
                        want.payload_out));
            end
        end
    end

    function automatic void compare_swap(bit up, int i, int j);
        bit    less;
        elem_t t;
        if (pred_by_dummy)
            less = shadow_store[i].dummy < shadow_store[j].dummy;
        else
            less = shadow_store[i].key < shadow_store[j].key;
        if (less != up)
        begin
            t = shadow_store[i];
            shadow_store[i] = shadow_store[j];
            shadow_store[j] = t;
        end
    endfunction

    function automatic void merge_range(bit up, int lo, int hi);
        int m;
        if (hi <= lo + 1)
            return;
        m = 1;
        while (m < hi - lo)
            m = m << 1;
        m = m >> 1;
        for (int i = lo; i < hi - m; i++)
            compare_swap(up, i, i + m);
        merge_range(up, lo, lo + m);
        merge_range(up, lo + m, hi);
    endfunction

    function automatic void sort_range(bit up, int lo, int hi);
        int mid;
        if (hi <= lo)
            return;
        mid = lo + (hi - lo) / 2;
        if (mid == lo)
            return;
        sort_range(!up, lo, mid);
        sort_range(up, mid, hi);
        merge_range(up, lo, hi);
    endfunction

    function automatic void predict_beat(in_beat_t b);
        out_beat_t r;
        int        lo;
        int        hi;
        r = '0;
        case (cmd_t'(b.cmd))
            CMD_WRITE:
            begin
                shadow_store[b.index] = '{b.key_in, b.dummy_in, b.payload_in};
                written[b.index] = 1'b1;
            end
            CMD_SORT:
            begin
                lo = (pred_first > DEPTH) ? DEPTH : pred_first;
                hi = (pred_end > DEPTH) ? DEPTH : pred_end;
                sort_range(pred_asc, lo, hi);
                r.sort_done = 1'b1;
                expected_beats.push_back(r);
            end
            CMD_READ:
            begin
                r.key_out = shadow_store[b.index].key;
                r.dummy_out = shadow_store[b.index].dummy;
                r.payload_out = shadow_store[b.index].payload;
                expected_beats.push_back(r);
            end
            default: ;
        endcase
    endfunction

    // valid stays up after the beat; the next gap or an idle phase drops it
    task automatic send_beat(input in_beat_t b);
        int gap;
        gap = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 40);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_beat(b);
    endtask

    task automatic send_cmd(input cmd_t c, input int idx, input logic [31:0] k,
                            input logic d, input logic [31:0] p);
        in_beat_t b;
        b.cmd = c;
        b.index = idx[INDEX_BITS-1:0];
        b.key_in = k;
        b.dummy_in = d;
        b.payload_in = p;
        send_beat(b);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_cfg(input cfg_idx_t idx, input int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_BITS-1:0];
        @(posedge clk);
        case (idx)
            CFG_SORT_ASC:    pred_asc = value[0];
            CFG_BY_DUMMY:    pred_by_dummy = value[0];
            CFG_RANGE_FIRST: pred_first = value & 11'h7ff;
            CFG_RANGE_END:   pred_end = value & 11'h7ff;
            default: ;
        endcase
    endtask

    task automatic set_sort(input bit asc, input bit by_dummy, input int first, input int last);
        drain();
        write_cfg(CFG_SORT_ASC, asc);
        write_cfg(CFG_BY_DUMMY, by_dummy);
        write_cfg(CFG_RANGE_FIRST, first);
        write_cfg(CFG_RANGE_END, last);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_key(bit dense);
        if (dense)
            return $urandom_range(0, 7);
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // read n random entries that have been written
    task automatic read_some(input int n);
        int idx;
        for (int k = 0; k < n; k++)
        begin
            idx = $urandom_range(0, DEPTH - 1);
            while (!written[idx])
                idx = $urandom_range(0, DEPTH - 1);
            send_cmd(CMD_READ, idx, $urandom, $urandom_range(0, 1), $urandom);
        end
    endtask

    task automatic test_directed();
        // extremes, no-op, full-store sort with default registers
        for (int i = 0; i < DEPTH; i++)
        begin
            shadow_store[i] = '0;
        end
        send_cmd(CMD_WRITE, 0, 32'h0, 1'b0, 32'h0);
        send_cmd(CMD_WRITE, DEPTH - 1, 32'hffff_ffff, 1'b1, 32'hffff_ffff);
        send_cmd(CMD_READ, 0, 32'hffff_ffff, 1'b1, 32'hffff_ffff);
        send_cmd(CMD_READ, DEPTH - 1, 32'h0, 1'b0, 32'h0);
        send_cmd(CMD_NOP, 5, 32'h1234, 1'b1, 32'h5678);
        send_cmd(CMD_WRITE, 1, 32'h8000_0000, 1'b1, 32'h5555_aaaa);
        send_cmd(CMD_READ, 1, 0, 0, 0);
        // fill all so a whole-store sort touches only written entries
        for (int i = 2; i < DEPTH - 1; i++)
            send_cmd(CMD_WRITE, i, rand_key(0), $urandom_range(0, 1), $urandom);
        send_cmd(CMD_SORT, 0, 0, 0, 0);
        read_some(8);
        // empty, single and reversed ranges still acknowledge
        set_sort(1, 0, 7, 7);
        send_cmd(CMD_SORT, 0, 0, 0, 0);
        set_sort(0, 0, 9, 10);
        send_cmd(CMD_SORT, 0, 0, 0, 0);
        set_sort(1, 1, 20, 3);
        send_cmd(CMD_SORT, 0, 0, 0, 0);
        // range beyond the store saturates
        set_sort(0, 1, 1000, 2047);
        send_cmd(CMD_SORT, 0, 0, 0, 0);
        read_some(4);
        set_sort(1, 0, 2047, 2047);
        send_cmd(CMD_SORT, 0, 0, 0, 0);
    endtask

    task automatic test_random_sorts();
        int first;
        int len;
        for (int s = 0; s < 8; s++)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 100) : $urandom_range(0, 24);
            first = $urandom_range(0, DEPTH - len);
            set_sort($urandom_range(0, 1), $urandom_range(0, 1), first, first + len);
            for (int i = 0; i < len; i++)
                send_cmd(CMD_WRITE, first + i, rand_key(s[0]), $urandom_range(0, 1), $urandom);
            send_cmd(CMD_SORT, 0, 0, 0, 0);
            for (int i = 0; i < len; i++)
                if ($urandom_range(0, 1) == 0)
                    send_cmd(CMD_READ, first + i, $urandom, $urandom_range(0, 1), $urandom);
            if ($urandom_range(0, 4) == 0)
                send_cmd(CMD_NOP, $urandom_range(0, DEPTH - 1), $urandom, 0, $urandom);
        end
    endtask

    task automatic test_back_pressure();
        // receiver stalls while reads keep coming, so the input has to stall
        drain();
        hold_cycles <= 0;
        hold_off <= 1'b1;
        read_some(40);
        in_valid <= 1'b0;
        while (hold_off)
            @(posedge clk);
        read_some(10);
    endtask

    task automatic test_random_mix();
        int idx;
        for (int k = 0; k < 40; k++)
        begin
            idx = $urandom_range(0, DEPTH - 1);
            if ($urandom_range(0, 1) == 0 || !written[idx])
                send_cmd(CMD_WRITE, idx, rand_key(0), $urandom_range(0, 1), $urandom);
            else
                send_cmd(cmd_t'($urandom_range(0, 9) == 0 ? CMD_NOP : CMD_READ), idx,
                    $urandom, $urandom_range(0, 1), $urandom);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_SORT_ASC;
        cfg_data = '0;
        hold_off = 1'b0;
        hold_cycles = 0;
        error_count = 0;
        cycle_count = 0;
        pred_asc = 1'b1;
        pred_by_dummy = 1'b0;
        pred_first = 0;
        pred_end = 1024;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_sorts();
        test_back_pressure();
        test_random_mix();
        drain();
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
